### rtl/albs_pkg.sv
// ---------------------------------------------------------------------------
// albs_pkg: shared types and constants for the append log search block
// Item and queue types passed between the front and the back, opcode codes
// and the back-end state encoding.
// ---------------------------------------------------------------------------
package albs_pkg;

	localparam int DEPTH_DEFAULT = 1024;
	localparam int TS_W          = 32;
	localparam int ADDR_W        = 32;
	localparam int SLOT_W        = 10;

	// Queue depth must be a power of two so that the pointers wrap on their own.
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_QUERY  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic              is_query;
		logic [TS_W-1:0]   ts;
		logic [ADDR_W-1:0] addr;
	} albs_item_t;

	typedef struct packed {
		logic       valid;
		albs_item_t item;
	} albs_queue_out_t;

	typedef enum logic {
		B_IDLE,
		B_SEARCH
	} back_state_t;

endpackage

### rtl/append_log_binary_search.sv
// ---------------------------------------------------------------------------
// append_log_binary_search: append-only timestamp log with binary search
// Appends store a timestamp and address pair; queries search the filled part
// of the log by timestamp and report hit, stored address and slot.
// ---------------------------------------------------------------------------
// A query runs P probes of the timestamp memory in the back end (one read port,
// one probe per cycle), P at most floor(log2(DEPTH)) + 1, that is 11 for 1024
// entries. Results are registered before done is raised; the receiver cannot
// stall, so results never wait.
// Reset clears the fill count and control state only; memories are not cleared.
module append_log_binary_search #(
	parameter int DEPTH = albs_pkg::DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             opcode,
	input  logic signed [albs_pkg::TS_W-1:0] key_timestamp,
	input  logic [albs_pkg::ADDR_W-1:0]      entry_address,
	output logic                             done,
	output logic                             found,
	output logic [albs_pkg::ADDR_W-1:0]      address_out,
	output logic [albs_pkg::SLOT_W-1:0]      slot_index
);
	import albs_pkg::*;

	// The front accepts a transfer whenever its two-entry queue has room, so
	// a burst of commands is absorbed while the back end is in a search.
	albs_queue_out_t q_out;
	logic            pop;

	albs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.opcode        (opcode),
		.key_timestamp (key_timestamp),
		.entry_address (entry_address),
		.busy          (busy),
		.pop           (pop),
		.q_out         (q_out)
	);

	// The back end takes one item at a time in queue order, so a query always
	// sees every append that was transferred before it. The search keeps the
	// window as [low, high) and stops at the first equal timestamp.
	albs_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_in        (q_out),
		.pop         (pop),
		.done        (done),
		.found       (found),
		.address_out (address_out),
		.slot_index  (slot_index)
	);

endmodule

### rtl/albs_front.sv
// ---------------------------------------------------------------------------
// albs_front: command intake and item queue
// Takes command transfers, tags each item as append or query and holds it in
// a short queue until the back end is ready to carry it out.
// ---------------------------------------------------------------------------
module albs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            opcode,
	input  logic signed [albs_pkg::TS_W-1:0] key_timestamp,
	input  logic [albs_pkg::ADDR_W-1:0]     entry_address,
	output logic                            busy,
	input  logic                            pop,
	output albs_pkg::albs_queue_out_t       q_out
);
	import albs_pkg::*;

	albs_item_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;
	logic               push;
	albs_item_t         new_item;

	assign busy = (fill_q == QFILL_W'(QUEUE_DEPTH));
	assign push = start && !busy;

	always_comb begin
		new_item.is_query = (opcode == OP_QUERY);
		new_item.ts       = key_timestamp;
		new_item.addr     = entry_address;
	end

	assign q_out.valid = (fill_q != '0);
	assign q_out.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + QFILL_W'(1);
				2'b01:   fill_q <= fill_q - QFILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### rtl/albs_back.sv
// ---------------------------------------------------------------------------
// albs_back: log storage and binary search engine
// Appends pairs to the timestamp and address memories and runs one search
// probe per cycle for queries, then registers the result for one cycle.
// ---------------------------------------------------------------------------
module albs_back #(
	parameter int DEPTH = albs_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  albs_pkg::albs_queue_out_t     q_in,
	output logic                          pop,
	output logic                          done,
	output logic                          found,
	output logic [albs_pkg::ADDR_W-1:0]   address_out,
	output logic [albs_pkg::SLOT_W-1:0]   slot_index
);
	import albs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [TS_W-1:0]   ts_mem [DEPTH];
	logic [ADDR_W-1:0] ad_mem [DEPTH];
	logic [TS_W-1:0]   ts_rd_q;
	logic [ADDR_W-1:0] ad_rd_q;

	back_state_t       state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     lo_q, lo_d;
	logic [CW-1:0]     hi_q, hi_d;     // exclusive upper bound of the window
	logic [AW-1:0]     mid_q, mid_d;
	logic [TS_W-1:0]   key_q, key_d;

	logic              done_q, res_done;
	logic              found_q, res_found;
	logic [ADDR_W-1:0] addr_q, res_addr;
	logic [AW-1:0]     slot_q, res_slot;
	logic [SLOT_W+AW-1:0] slot_ext;

	logic              mem_we;
	logic [AW-1:0]     rd_addr;

	logic              probe_hit;
	logic [CW-1:0]     lo_n, hi_n;
	logic              window_empty;
	logic [AW-1:0]     next_mid;
	logic [AW-1:0]     first_mid;
	logic              store_full;

	// Probe datapath: compare the entry read for mid_q and narrow the window.
	always_comb begin
		probe_hit = (ts_rd_q == key_q);
		if ($signed(ts_rd_q) < $signed(key_q)) begin
			lo_n = CW'(mid_q) + CW'(1);
			hi_n = hi_q;
		end else begin
			lo_n = lo_q;
			hi_n = CW'(mid_q);
		end
		window_empty = (lo_n >= hi_n);
		next_mid     = AW'(lo_n + ((hi_n - CW'(1) - lo_n) >> 1));
		first_mid    = AW'((count_q - CW'(1)) >> 1);
		store_full   = (count_q == CW'(DEPTH));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_in.valid && q_in.item.is_query && (count_q != '0)) begin
					state_d = B_SEARCH;
				end
			end
			B_SEARCH: begin
				if (probe_hit || window_empty) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Control and result outputs.
	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		rd_addr   = mid_q;
		count_d   = count_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		key_d     = key_q;
		res_done  = 1'b0;
		res_found = 1'b0;
		res_addr  = '0;
		res_slot  = '0;
		unique case (state_q)
			B_IDLE: begin
				if (q_in.valid) begin
					pop = 1'b1;
					if (!q_in.item.is_query) begin
						if (!store_full) begin
							mem_we  = 1'b1;
							count_d = count_q + CW'(1);
						end
					end else begin
						key_d = q_in.item.ts;
						lo_d  = '0;
						hi_d  = count_q;
						if (count_q == '0) begin
							res_done = 1'b1;
						end else begin
							mid_d   = first_mid;
							rd_addr = first_mid;
						end
					end
				end
			end
			B_SEARCH: begin
				if (probe_hit) begin
					res_done  = 1'b1;
					res_found = 1'b1;
					res_addr  = ad_rd_q;
					res_slot  = mid_q;
				end else if (window_empty) begin
					res_done = 1'b1;
				end else begin
					lo_d    = lo_n;
					hi_d    = hi_n;
					mid_d   = next_mid;
					rd_addr = next_mid;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Log memories, written at the fill count, read with a registered port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ts_mem[count_q[AW-1:0]] <= q_in.item.ts;
			ad_mem[count_q[AW-1:0]] <= q_in.item.addr;
		end
		ts_rd_q <= ts_mem[rd_addr];
		ad_rd_q <= ad_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		mid_q   <= mid_d;
		key_q   <= key_d;
		found_q <= res_found;
		addr_q  <= res_addr;
		slot_q  <= res_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= res_done;
		end
	end

	assign slot_ext    = {{SLOT_W{1'b0}}, slot_q};
	assign done        = done_q;
	assign found       = found_q;
	assign address_out = addr_q;
	assign slot_index  = slot_ext[SLOT_W-1:0];

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench for append_log_binary_search
// Drives append and query transfers through the start/busy handshake and
// checks every done strobe against a lookup model of the log.
// ---------------------------------------------------------------------------
module tb;

	import albs_pkg::*;

	localparam int LOG_DEPTH   = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DIR_ROWS    = 18;

	// One lookup answer: hit flag, stored address and slot of the hit.
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] addr;
		logic [SLOT_W-1:0] slot;
	} lookup_t;

	// One row of the directed table. Rows with fixed_answer set carry the
	// answer written out by hand; the others are checked by the lookup model.
	typedef struct packed {
		opcode_t           op;
		logic [TS_W-1:0]   ts;
		logic [ADDR_W-1:0] addr;
		logic              fixed_answer;
		lookup_t           answer;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	opcode_t           opcode;
	logic [TS_W-1:0]   key_timestamp;
	logic [ADDR_W-1:0] entry_address;
	logic              done;
	logic              found;
	logic [ADDR_W-1:0] address_out;
	logic [SLOT_W-1:0] slot_index;

	// Shadow copy of the log, updated at every accepted append while it has room.
	logic [TS_W-1:0]   log_ts   [LOG_DEPTH];
	logic [ADDR_W-1:0] log_addr [LOG_DEPTH];
	int                log_fill;

	// Answers still owed by the block, oldest first.
	lookup_t           pending_lookups [$];

	int                mismatch_count;
	int                cycle_count;
	longint            next_ts;
	int                row_idx;

	// The directed table walks the corners first: a query of the empty log,
	// then a small sorted log holding both timestamp extremes, with hits at
	// the ends and in the middle, misses right next to the extremes, and a
	// query whose address field is junk that must be ignored. The last rows
	// append out of order so that the log is no longer sorted; from then on
	// the search may legally miss a timestamp that is present, and only the
	// lookup model knows which answer is right.
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{OP_QUERY,  32'h0000_0005, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 10'd0}},
		'{OP_APPEND, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0},
		'{OP_APPEND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{OP_APPEND, 32'h0000_0000, 32'h1234_5678, 1'b0, '0},
		'{OP_APPEND, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, '0},
		'{OP_APPEND, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b0, '0},
		'{OP_QUERY,  32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 10'd0}},
		'{OP_QUERY,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h5A5A_5A5A, 10'd4}},
		'{OP_QUERY,  32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h1234_5678, 10'd2}},
		'{OP_QUERY,  32'h0000_0005, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 10'd0}},
		'{OP_QUERY,  32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b1, '{1'b1, 32'h0000_0000, 10'd1}},
		'{OP_QUERY,  32'h7FFF_FFFE, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 10'd0}},
		'{OP_QUERY,  32'h8000_0001, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 10'd0}},
		'{OP_APPEND, 32'h0000_0064, 32'hC0A8_0001, 1'b0, '0},
		'{OP_APPEND, 32'hFFFF_FFCE, 32'h0A00_0001, 1'b0, '0},
		'{OP_QUERY,  32'h0000_0064, 32'h0000_0000, 1'b0, '0},
		'{OP_QUERY,  32'hFFFF_FFCE, 32'h0000_0000, 1'b0, '0},
		'{OP_QUERY,  32'h0000_0002, 32'h0000_0000, 1'b0, '0}
	};

	append_log_binary_search u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.key_timestamp (key_timestamp),
		.entry_address (entry_address),
		.done          (done),
		.found         (found),
		.address_out   (address_out),
		.slot_index    (slot_index)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = ~clk;
	end

	// Binary search over the filled slots exactly as the block must run it:
	// probe at low plus half the span rounded down, signed compare, and stop
	// at the first equal timestamp. Only filled slots are ever probed.
	function automatic lookup_t search_log(logic [TS_W-1:0] key);
		lookup_t answer;
		int      lo;
		int      hi;
		int      mid;
		answer = '0;
		lo     = 0;
		hi     = log_fill - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if ($signed(log_ts[mid]) == $signed(key)) begin
				answer.hit  = 1'b1;
				answer.addr = log_addr[mid];
				answer.slot = mid[SLOT_W-1:0];
				break;
			end else if ($signed(log_ts[mid]) < $signed(key)) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return answer;
	endfunction

	task automatic note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endtask

	// Must be called at a falling edge. Presents one item and holds it until
	// the transfer happens; start is left high so the next item can follow
	// back to back without a gap.
	task automatic put_item(opcode_t op, logic [TS_W-1:0] ts, logic [ADDR_W-1:0] addr);
		start         <= 1'b1;
		opcode        <= op;
		key_timestamp <= ts;
		entry_address <= addr;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
	endtask

	// Sender pause: drop start and wait for every owed answer to come back.
	task automatic drain_lookups();
		@(negedge clk);
		start <= 1'b0;
		while (pending_lookups.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Random traffic. Appends mostly grow the timestamp so the log stays
	// sorted and queries get deep into the search; a few appends land at a
	// random spot as noise. Queries mostly ask for a stored timestamp, some
	// for a neighbor of one, and the rest for any value at all.
	task automatic run_random(int items, int idle_pct);
		opcode_t           op;
		logic [TS_W-1:0]   ts;
		logic [ADDR_W-1:0] addr;
		int                pick;
		int                slot;
		repeat (items) begin
			while ($urandom_range(99) < idle_pct) begin
				@(negedge clk);
				start <= 1'b0;
			end
			@(negedge clk);
			op   = ($urandom_range(99) < 50) ? OP_APPEND : OP_QUERY;
			addr = $urandom;
			pick = $urandom_range(99);
			slot = (log_fill > 0) ? $urandom_range(log_fill - 1) : 0;
			if (op == OP_APPEND) begin
				if (pick < 5) begin
					ts = $urandom;
				end else begin
					next_ts = next_ts + $urandom_range(0, 1 << 21);
					if (next_ts > 64'sd2147483647) begin
						next_ts = 64'sd2147483647;
					end
					ts = next_ts[TS_W-1:0];
				end
			end else if (log_fill > 0 && pick < 55) begin
				ts = log_ts[slot];
			end else if (log_fill > 0 && pick < 70) begin
				ts = ($urandom_range(1) == 1) ? log_ts[slot] + 32'd1 : log_ts[slot] - 32'd1;
			end else begin
				ts = $urandom;
			end
			put_item(op, ts, addr);
		end
	endtask

	// Monitor and scoreboard. Both the done strobe and the transfer are
	// sampled at the rising edge; an answer due now is retired before a new
	// query is queued, and a new query can never answer in the same cycle.
	always @(posedge clk) begin
		lookup_t owed;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_lookups.size() == 0) begin
					note_mismatch($sformatf("result with no query pending: found=%0b addr=%h slot=%0d",
						found, address_out, slot_index));
				end else begin
					owed = pending_lookups.pop_front();
					if (found !== owed.hit || address_out !== owed.addr
							|| slot_index !== owed.slot) begin
						note_mismatch($sformatf({"expected found=%0b addr=%h slot=%0d, ",
							"got found=%0b addr=%h slot=%0d"}, owed.hit, owed.addr,
							owed.slot, found, address_out, slot_index));
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				if (opcode == OP_APPEND) begin
					// An append into a full log is dropped silently.
					if (log_fill < LOG_DEPTH) begin
						log_ts[log_fill]   = key_timestamp;
						log_addr[log_fill] = entry_address;
						log_fill++;
					end
				end else begin
					pending_lookups.push_back(search_log(key_timestamp));
				end
			end
		end
	end

	// Watchdog: the slowest legal run is far below this.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		opcode         = OP_APPEND;
		key_timestamp  = '0;
		entry_address  = '0;
		log_fill       = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		next_ts        = -50;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. Hand-written answers replace the model's answer for
		// their row; the model still tracks the log for every row.
		for (row_idx = 0; row_idx < DIR_ROWS; row_idx++) begin
			@(negedge clk);
			put_item(directed_rows[row_idx].op, directed_rows[row_idx].ts,
				directed_rows[row_idx].addr);
			if (directed_rows[row_idx].op == OP_QUERY && directed_rows[row_idx].fixed_answer) begin
				@(negedge clk);
				void'(pending_lookups.pop_back());
				pending_lookups.push_back(directed_rows[row_idx].answer);
				start <= 1'b0;
			end
		end
		drain_lookups();

		// Three random phases: a lightly idling sender, a mostly idle one,
		// and one with no gaps at all. Each ends with the sender holding off
		// until every answer is back.
		run_random(180, 20);
		drain_lookups();
		run_random(180, 83);
		drain_lookups();
		run_random(180, 0);
		drain_lookups();

		// Fill the log to the last slot with sorted timestamps, then push
		// appends at the full log, which must be dropped, and search the full
		// log, including the slot at the top of the index range.
		forever begin
			@(negedge clk);
			if (log_fill >= LOG_DEPTH) begin
				start <= 1'b0;
				break;
			end
			next_ts = next_ts + $urandom_range(0, 1 << 20);
			if (next_ts > 64'sd2147483647) begin
				next_ts = 64'sd2147483647;
			end
			put_item(OP_APPEND, next_ts[TS_W-1:0], $urandom);
		end
		repeat (8) begin
			@(negedge clk);
			put_item(OP_APPEND, $urandom, $urandom);
		end
		@(negedge clk);
		put_item(OP_QUERY, log_ts[LOG_DEPTH-1], $urandom);
		@(negedge clk);
		put_item(OP_QUERY, log_ts[0], $urandom);
		repeat (30) begin
			@(negedge clk);
			put_item(OP_QUERY, ($urandom_range(3) == 0) ? $urandom
				: log_ts[$urandom_range(LOG_DEPTH - 1)], $urandom);
		end
		drain_lookups();

		// Give a stray strobe time to show up before closing the run.
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && pending_lookups.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
